[src/pal_pkg.sv]
// Shared types, constants and codes of the three-axis PID attitude loop.
package pal_pkg;

  localparam int INTEGRATOR_WIDTH_DEF = 32;
  localparam int NUM_AXES             = 3;
  localparam int FIELD_W              = 16;
  localparam int GAINS_W              = 48;
  localparam int STEP_W               = 16;
  localparam int LIMIT_W              = 15;
  localparam int CFG_ADDR_W           = 3;
  localparam int CFG_DATA_W           = 48;
  localparam int MUL_A_W              = 17;
  localparam int MUL_B_W              = 33;
  localparam int PROD_W               = MUL_A_W + MUL_B_W;
  localparam int PROD_FRAC            = 27;
  localparam int TERM_FRAC            = 19;
  localparam int ACC_W                = 40;

  localparam logic [STEP_W-1:0]  STEP_TIME_RST = STEP_W'(655);
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = LIMIT_W'(1024);

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_ROLL  = 2'd0;
  localparam axis_t AXIS_PITCH = 2'd1;
  localparam axis_t AXIS_YAW   = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROLL_GAINS,
    REG_PITCH_GAINS,
    REG_YAW_GAINS,
    REG_STEP_TIME,
    REG_ROLL_LIMIT
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC,
    OP_KP,
    OP_KD,
    OP_KILO,
    OP_KIHI,
    OP_FIN,
    OP_TORQ
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  capture;
    op_t   op;
    axis_t axis;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_target;
    logic signed [FIELD_W-1:0] pitch_target;
    logic signed [FIELD_W-1:0] yaw_target;
    logic signed [FIELD_W-1:0] roll_measured;
    logic signed [FIELD_W-1:0] pitch_measured;
    logic signed [FIELD_W-1:0] yaw_measured;
    logic signed [FIELD_W-1:0] roll_rate;
    logic signed [FIELD_W-1:0] pitch_rate;
    logic signed [FIELD_W-1:0] yaw_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] roll_torque;
    logic signed [FIELD_W-1:0] pitch_torque;
    logic signed [FIELD_W-1:0] yaw_torque;
    logic                      roll_clamped;
    logic signed [FIELD_W-1:0] roll_error;
    logic signed [FIELD_W-1:0] pitch_error;
    logic signed [FIELD_W-1:0] yaw_error;
  } out_item_t;

endpackage

[src/pal_if.sv]
// Channel interfaces of the attitude loop: input items, results and register writes.
interface pal_in_if;
  logic              valid;
  logic              ready;
  pal_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pal_out_if;
  logic               valid;
  logic               ready;
  pal_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pal_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pal_pkg::CFG_ADDR_W-1:0]    addr;
  logic [pal_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

[src/three_axis_pid_attitude_loop.sv]
// Top level of the three-axis PID attitude loop with integrator-reset anti-windup.
// One transfer on in_item carries a control tick: target angle, measured angle and
// measured rate for roll, pitch and yaw. One transfer on out_item returns the
// three torques, the roll clamp flag and the three angle errors for that tick.
// Gains, step time and the roll torque limit are written through cfg_wr, which
// is always ready; the user must see that writes are made while no tick is in
// flight, as the block does not enforce it. A tick is accepted only while the
// sequencer is idle. It then runs 21 slots on the one shared 17 x 33 bit
// multiplier (seven per axis: integrator step, kp, kd, two halves of ki, final
// sum, torque shaping), then a drain state and a state that loads the output
// register; no new tick is taken until that load is done.
// The output register parts the two sides: the next tick is accepted while the
// previous result still waits; if the receiver stalls longer than a tick takes,
// the finished tick holds until the output register frees up.
// Synchronous reset clears the integrators and the saturation flag, zeroes the
// gains, and sets the step time to 655 and the roll limit to 1024.
module three_axis_pid_attitude_loop #(
  parameter int INTEGRATOR_WIDTH = pal_pkg::INTEGRATOR_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pal_in_if.sink     in_item,
  pal_out_if.source  out_item,
  pal_cfg_if.sink    cfg_wr
);
  import pal_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_item.ready = in_ready;
  assign cfg_wr.ready  = 1'b1;

  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pal_datapath #(
    .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_item.data),
    .cfg_valid (cfg_wr.valid),
    .cfg_addr  (cfg_wr.addr),
    .cfg_data  (cfg_wr.data),
    .out_ready (out_item.ready),
    .out_valid (out_item.valid),
    .out_data  (out_item.data)
  );

endmodule

[src/pal_ctrl.sv]
// Sequencer that steps the shared multiplier through the seven slots of each axis.
module pal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pal_pkg::sts_t sts,
  output pal_pkg::cmd_t cmd
);
  import pal_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  axis_t  axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_NONE;
      axis_r  <= AXIS_ROLL;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    axis_nxt     = axis_r;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.op       = OP_NONE;
    cmd.axis     = axis_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RUN;
          op_nxt      = OP_INC;
          axis_nxt    = AXIS_ROLL;
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        unique case (op_r)
          OP_INC:  op_nxt = OP_KP;
          OP_KP:   op_nxt = OP_KD;
          OP_KD:   op_nxt = OP_KILO;
          OP_KILO: op_nxt = OP_KIHI;
          OP_KIHI: op_nxt = OP_FIN;
          OP_FIN:  op_nxt = OP_TORQ;
          OP_TORQ: begin
            op_nxt = OP_INC;
            if (axis_r == AXIS_YAW) begin
              state_nxt = ST_DRAIN;
            end else begin
              axis_nxt = axis_t'(axis_r + 2'd1);
            end
          end
          default: op_nxt = OP_INC;
        endcase
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/pal_datapath.sv]
// Datapath: registers, error forming, shared multiplier, integrators and torque shaping.
module pal_datapath #(
  parameter int INTEGRATOR_WIDTH = pal_pkg::INTEGRATOR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pal_pkg::cmd_t                    cmd,
  output pal_pkg::sts_t                    sts,
  input  pal_pkg::in_item_t                in_data,
  input  logic                             cfg_valid,
  input  logic [pal_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pal_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output pal_pkg::out_item_t               out_data
);
  import pal_pkg::*;

  localparam int IW   = INTEGRATOR_WIDTH;
  localparam int IF   = IW - 8;
  localparam int RSH  = (IF < PROD_FRAC) ? PROD_FRAC - IF : 0;
  localparam int LSH  = (IF >= PROD_FRAC) ? IF - PROD_FRAC : 0;
  localparam int KIW  = IW + MUL_A_W;
  localparam int KSH  = IW - TERM_FRAC;

  localparam logic signed [KIW-1:0]   KiHalf    = KIW'(1) << (KSH - 1);
  localparam logic signed [ACC_W-1:0] TorqHalf  = ACC_W'(128);
  localparam logic signed [ACC_W-1:0] SatHi     = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SatLo     = -ACC_W'(32768);

  logic [GAINS_W-1:0]        gains_r [NUM_AXES];
  logic [STEP_W-1:0]         step_time_r;
  logic [LIMIT_W-1:0]        limit_r;

  logic signed [FIELD_W-1:0] err_r  [NUM_AXES];
  logic signed [FIELD_W-1:0] derr_r [NUM_AXES];
  logic signed [FIELD_W-1:0] err_nxt  [NUM_AXES];
  logic signed [FIELD_W-1:0] derr_nxt [NUM_AXES];
  logic signed [IW-1:0]      integ_r [NUM_AXES];
  logic                      sat_r;
  logic                      clear_r;

  op_t                       op_d_r;
  axis_t                     ax_d_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   sum_r;
  logic signed [KIW-1:0]     kiacc_r;
  logic signed [KIW-1:0]     kifull_r;
  logic signed [FIELD_W-1:0] torq_r [NUM_AXES];
  logic                      clamp_r;

  logic                      out_valid_r;
  out_item_t                 out_r;

  logic [GAINS_W-1:0]        gsel;
  logic signed [FIELD_W-1:0] esel;
  logic signed [FIELD_W-1:0] dsel;
  logic signed [IW-1:0]      isel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  logic signed [IW-1:0]      inc;
  logic signed [IW:0]        isum;
  logic signed [IW-1:0]      integ_new;
  logic signed [KIW-1:0]     kiround;
  logic signed [ACC_W-1:0]   tq;
  logic signed [FIELD_W-1:0] tq16;
  logic                      clamp_now;
  logic signed [ACC_W-1:0]   limx;

  logic signed [FIELD_W-1:0] tgt  [NUM_AXES];
  logic signed [FIELD_W-1:0] meas [NUM_AXES];
  logic signed [FIELD_W-1:0] rate [NUM_AXES];
  logic signed [FIELD_W:0]   diff [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r[AXIS_ROLL]  <= '0;
      gains_r[AXIS_PITCH] <= '0;
      gains_r[AXIS_YAW]   <= '0;
      step_time_r         <= STEP_TIME_RST;
      limit_r             <= LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_ROLL_GAINS:  gains_r[AXIS_ROLL]  <= cfg_data[GAINS_W-1:0];
        REG_PITCH_GAINS: gains_r[AXIS_PITCH] <= cfg_data[GAINS_W-1:0];
        REG_YAW_GAINS:   gains_r[AXIS_YAW]   <= cfg_data[GAINS_W-1:0];
        REG_STEP_TIME:   step_time_r         <= cfg_data[STEP_W-1:0];
        REG_ROLL_LIMIT:  limit_r             <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tgt[AXIS_ROLL]   = in_data.roll_target;
    tgt[AXIS_PITCH]  = in_data.pitch_target;
    tgt[AXIS_YAW]    = in_data.yaw_target;
    meas[AXIS_ROLL]  = in_data.roll_measured;
    meas[AXIS_PITCH] = in_data.pitch_measured;
    meas[AXIS_YAW]   = in_data.yaw_measured;
    rate[AXIS_ROLL]  = in_data.roll_rate;
    rate[AXIS_PITCH] = in_data.pitch_rate;
    rate[AXIS_YAW]   = in_data.yaw_rate;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = (FIELD_W + 1)'(tgt[a]) - (FIELD_W + 1)'(meas[a]);
      if (diff[a][FIELD_W] != diff[a][FIELD_W-1]) begin
        err_nxt[a] = diff[a][FIELD_W] ? 16'sh8000 : 16'sh7fff;
      end else begin
        err_nxt[a] = diff[a][FIELD_W-1:0];
      end
      if (rate[a] == 16'sh8000) begin
        derr_nxt[a] = 16'sh7fff;
      end else begin
        derr_nxt[a] = -rate[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err_r   <= err_nxt;
      derr_r  <= derr_nxt;
      clear_r <= sat_r;
    end
  end

  // The axis stays put for all seven slots, so the entry chosen at issue is
  // also the one the consume stage updates.
  always_comb begin
    gsel  = gains_r[cmd.axis];
    esel  = err_r[cmd.axis];
    dsel  = derr_r[cmd.axis];
    isel  = integ_r[cmd.axis];
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_INC: begin
        mul_a = $signed({1'b0, step_time_r});
        mul_b = MUL_B_W'(esel);
      end
      OP_KP: begin
        mul_a = $signed({1'b0, gsel[47:32]});
        mul_b = MUL_B_W'(esel);
      end
      OP_KD: begin
        mul_a = $signed({1'b0, gsel[15:0]});
        mul_b = MUL_B_W'(dsel);
      end
      OP_KILO: begin
        mul_a = $signed({1'b0, gsel[31:16]});
        mul_b = $signed({{(MUL_B_W - 16){1'b0}}, isel[15:0]});
      end
      OP_KIHI: begin
        mul_a = $signed({1'b0, gsel[31:16]});
        mul_b = MUL_B_W'($signed(isel[IW-1:16]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_d_r <= OP_NONE;
    end else begin
      op_d_r <= cmd.op;
    end
    ax_d_r <= cmd.axis;
    p_r    <= mul_a * mul_b;
  end

  if (IF < PROD_FRAC) begin : g_inc_round
    localparam logic signed [PROD_W-1:0] IncHalf = PROD_W'(1) << (RSH - 1);
    logic signed [PROD_W-1:0] inc_full;
    assign inc_full = (p_r + IncHalf) >>> RSH;
    assign inc      = IW'(inc_full);
  end else begin : g_inc_shift
    logic signed [PROD_W-1:0] inc_full;
    assign inc_full = p_r <<< LSH;
    assign inc      = IW'(inc_full);
  end

  always_comb begin
    isum = (IW + 1)'(isel) + (IW + 1)'(inc);
    if (isum[IW] != isum[IW-1]) begin
      integ_new = isum[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
    end else begin
      integ_new = isum[IW-1:0];
    end
    kiround = (kifull_r + KiHalf) >>> KSH;
    tq      = (sum_r + TorqHalf) >>> 8;
    limx    = ACC_W'($signed({1'b0, limit_r}));
    clamp_now = 1'b0;
    if (ax_d_r == AXIS_ROLL) begin
      if (tq > limx) begin
        tq16      = limx[FIELD_W-1:0];
        clamp_now = 1'b1;
      end else if (tq < -limx) begin
        tq16      = FIELD_W'(-limx);
        clamp_now = 1'b1;
      end else begin
        tq16 = tq[FIELD_W-1:0];
      end
    end else if (tq > SatHi) begin
      tq16 = 16'sh7fff;
    end else if (tq < SatLo) begin
      tq16 = 16'sh8000;
    end else begin
      tq16 = tq[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r[AXIS_ROLL]  <= '0;
      integ_r[AXIS_PITCH] <= '0;
      integ_r[AXIS_YAW]   <= '0;
      sat_r               <= 1'b0;
    end else begin
      if (op_d_r == OP_INC) begin
        integ_r[ax_d_r] <= clear_r ? '0 : integ_new;
      end
      if (op_d_r == OP_TORQ && ax_d_r == AXIS_ROLL) begin
        sat_r <= clamp_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op_d_r)
      OP_KP:   acc_r    <= ACC_W'(p_r);
      OP_KD:   acc_r    <= acc_r + ACC_W'(p_r);
      OP_KILO: kiacc_r  <= KIW'(p_r);
      OP_KIHI: kifull_r <= kiacc_r + (KIW'(p_r) <<< 16);
      OP_FIN:  sum_r    <= acc_r + ACC_W'(kiround);
      OP_TORQ: begin
        torq_r[ax_d_r] <= tq16;
        if (ax_d_r == AXIS_ROLL) begin
          clamp_r <= clamp_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.roll_torque  <= torq_r[AXIS_ROLL];
      out_r.pitch_torque <= torq_r[AXIS_PITCH];
      out_r.yaw_torque   <= torq_r[AXIS_YAW];
      out_r.roll_clamped <= clamp_r;
      out_r.roll_error   <= err_r[AXIS_ROLL];
      out_r.pitch_error  <= err_r[AXIS_PITCH];
      out_r.yaw_error    <= err_r[AXIS_YAW];
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
